>>> rtl/date_span_calculator_unit_assert.svh
// Assertion macros shared by the date span calculator.
`ifndef DATE_SPAN_CALCULATOR_UNIT_ASSERT_SVH
`define DATE_SPAN_CALCULATOR_UNIT_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define DSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// The condition must never be seen at a clock edge outside reset.
`define DSC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

>>> rtl/dsc_pkg.sv
`default_nettype none

package dsc_pkg;

  localparam int unsigned DateW   = 27;
  localparam int unsigned YearW   = 14;
  localparam int unsigned MmddW   = 14;
  localparam int unsigned SerialW = 23;
  localparam int unsigned DiffW   = 23;

  // Month-day codes for the leap-day anniversary rule.
  localparam logic [MmddW-1:0] FebLeapDay = 14'd229;
  localparam logic [MmddW-1:0] FebLastDay = 14'd228;

  typedef struct packed {
    logic [DateW-1:0] begin_date;
    logic [DateW-1:0] end_date;
  } in_item_t;

  typedef struct packed {
    logic signed [DiffW-1:0] day_difference;
    logic [YearW-1:0]        whole_years;
  } result_t;

  // What one date pipeline hands to the final stage.
  typedef struct packed {
    logic [SerialW-1:0] serial;
    logic [YearW-1:0]   year;
    logic [MmddW-1:0]   mmdd;
    logic               leap;
  } date_info_t;

  // Exact floor(x / 25) for any 12-bit x, by reciprocal multiplication.
  function automatic logic [7:0] div25(input logic [11:0] x);
    logic [24:0] prod;
    prod = x * 13'd5243;
    return prod[24:17];
  endfunction

  // Days in the months before the given month (1..12).
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dsc_date_serial.sv
`default_nettype none

// Four-stage pipeline that turns one YYYYMMDD date into a serial day count.
module dsc_date_serial (
  input  wire logic                        clk_i,
  input  wire logic [dsc_pkg::DateW-1:0]   date_i,
  output dsc_pkg::date_info_t              info_o
);

  // Stage 1: year = date / 10000, done as (date >> 4) / 625 by reciprocal.
  logic [46:0]                 year_prod;
  logic [dsc_pkg::YearW-1:0]   year_q1;
  logic [dsc_pkg::DateW-1:0]   date_q1;

  assign year_prod = date_i[26:4] * 24'd13743896;

  always_ff @(posedge clk_i) begin
    year_q1 <= year_prod[46:33];
    date_q1 <= date_i;
  end

  // Stage 2: month-day remainder, year times 365, leap days and leap flag.
  logic [27:0]                 year_x10000;
  logic [dsc_pkg::DateW-1:0]   rem_full;
  logic [22:0]                 year_x365;
  logic [dsc_pkg::YearW-1:0]   prev_year;
  logic [7:0]                  q100_y, q100_p, q400_y, q400_p;
  logic [11:0]                 leap_days_d;
  logic                        leap_d;
  logic                        year_zero;

  logic [dsc_pkg::YearW-1:0]   year_q2;
  logic [dsc_pkg::MmddW-1:0]   mmdd_q2;
  logic [22:0]                 year_x365_q2;
  logic [11:0]                 leap_days_q2;
  logic                        leap_q2;

  assign year_x10000 = year_q1 * 14'd10000;
  assign rem_full    = date_q1 - year_x10000[26:0];
  assign year_x365   = year_q1 * 9'd365;
  assign prev_year   = year_q1 - 14'd1;
  assign year_zero   = (year_q1 == '0);

  assign q100_y = dsc_pkg::div25(year_q1[13:2]);
  assign q100_p = dsc_pkg::div25(prev_year[13:2]);
  assign q400_y = dsc_pkg::div25({2'b00, year_q1[13:4]});
  assign q400_p = dsc_pkg::div25({2'b00, prev_year[13:4]});

  // For a nonzero year, y is a multiple of n exactly when y / n and (y - 1) / n differ.
  always_comb begin
    if (year_zero) begin
      leap_d      = 1'b1;
      leap_days_d = '0;
    end else begin
      leap_d      = ((year_q1[1:0] == 2'b00) && (q100_y == q100_p)) || (q400_y != q400_p);
      leap_days_d = prev_year[13:2] - {4'b0000, q100_p} + {4'b0000, q400_p};
    end
  end

  always_ff @(posedge clk_i) begin
    year_q2      <= year_q1;
    mmdd_q2      <= rem_full[13:0];
    year_x365_q2 <= year_x365;
    leap_days_q2 <= leap_days_d;
    leap_q2      <= leap_d;
  end

  // Stage 3: month = mmdd / 100, and the year part of the serial count.
  logic [7:0]                  month_full;
  logic [6:0]                  month_q3;
  logic [dsc_pkg::MmddW-1:0]   mmdd_q3;
  logic [dsc_pkg::YearW-1:0]   year_q3;
  logic [dsc_pkg::SerialW-1:0] base_q3;
  logic                        leap_q3;

  assign month_full = dsc_pkg::div25(mmdd_q2[13:2]);

  always_ff @(posedge clk_i) begin
    month_q3 <= month_full[6:0];
    mmdd_q3  <= mmdd_q2;
    year_q3  <= year_q2;
    base_q3  <= year_x365_q2 + {11'd0, leap_days_q2};
    leap_q3  <= leap_q2;
  end

  // Stage 4: day, clamped month offset, and the final serial count.
  logic [dsc_pkg::MmddW-1:0]   month_x100;
  logic [dsc_pkg::MmddW-1:0]   day_full;
  logic [3:0]                  month_clamped;
  logic [8:0]                  offset;
  logic                        after_feb;
  dsc_pkg::date_info_t         info_d, info_q;

  assign month_x100 = month_q3 * 14'd100;
  assign day_full   = mmdd_q3 - month_x100;

  always_comb begin
    if (month_q3 == 7'd0) begin
      month_clamped = 4'd1;
    end else if (month_q3 > 7'd12) begin
      month_clamped = 4'd12;
    end else begin
      month_clamped = month_q3[3:0];
    end
    offset    = dsc_pkg::month_start(month_clamped);
    after_feb = leap_q3 && (month_clamped > 4'd2);

    info_d.serial = base_q3 + {14'd0, offset} + {22'd0, after_feb} + {16'd0, day_full[6:0]};
    info_d.year   = year_q3;
    info_d.mmdd   = mmdd_q3;
    info_d.leap   = leap_q3;
  end

  always_ff @(posedge clk_i) begin
    info_q <= info_d;
  end

  assign info_o = info_q;

endmodule

`default_nettype wire

>>> rtl/date_span_calculator_unit.sv
`default_nettype none

// Day span between two Gregorian dates given as decimal YYYYMMDD. An item is
// taken in every cycle that start is high (busy stays low, as nothing inside
// ever has to wait), and its result appears on result_o with result_valid_o
// high for one cycle once it has passed the five-stage pipeline: year split,
// month-day split and leap counts, month split, serial day sum, and the final
// difference with saturation and the whole-year count. Results cannot be held
// off, so they must be taken in the cycle they are shown.
module date_span_calculator_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output      logic             busy,
  input  wire dsc_pkg::in_item_t item_i,
  output      logic             result_valid_o,
  output dsc_pkg::result_t      result_o
);

  localparam int unsigned Depth = 5;

  logic                accept;
  logic                swapped;
  logic                same_dates;
  logic [Depth-1:0]    vld_q;
  logic [Depth-2:0]    end_before_q;
  dsc_pkg::date_info_t begin_info, end_info;
  dsc_pkg::result_t    result_d, result_q;

  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign swapped    = (item_i.end_date < item_i.begin_date);
  assign same_dates = (item_i.end_date == item_i.begin_date);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Depth-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    end_before_q <= {end_before_q[Depth-3:0], swapped};
  end

  dsc_date_serial u_begin (
    .clk_i  (clk_i),
    .date_i (item_i.begin_date),
    .info_o (begin_info)
  );

  dsc_date_serial u_end (
    .clk_i  (clk_i),
    .date_i (item_i.end_date),
    .info_o (end_info)
  );

  logic signed [23:0]         diff;
  logic [dsc_pkg::YearW-1:0]  year_span;
  logic                       full_year;

  always_comb begin
    diff = $signed({1'b0, end_info.serial}) - $signed({1'b0, begin_info.serial});
    if (diff > 24'sd4194303) begin
      result_d.day_difference = 23'sd4194303;
    end else if (diff < -24'sd4194304) begin
      result_d.day_difference = -23'sd4194304;
    end else begin
      result_d.day_difference = diff[22:0];
    end

    // Feb 29 to Feb 28 of a later year counts as a complete year.
    year_span = end_info.year - begin_info.year;
    full_year = (end_info.mmdd >= begin_info.mmdd) ||
                (begin_info.leap && (begin_info.mmdd == dsc_pkg::FebLeapDay) &&
                 (end_info.mmdd == dsc_pkg::FebLastDay));
    if (end_before_q[Depth-2]) begin
      result_d.whole_years = '0;
    end else if (full_year) begin
      result_d.whole_years = year_span;
    end else begin
      result_d.whole_years = year_span - 14'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = vld_q[Depth-1];
  assign result_o       = result_q;

`include "date_span_calculator_unit_assert.svh"

  `DSC_ASSERT_NEVER(a_strobe_needs_item, clk_i, rst_ni, result_valid_o && !$past(accept, Depth))
  `DSC_ASSERT_IMPL(a_same_date_zero, clk_i, rst_ni, $past(same_dates, Depth), result_o == '0)
  `DSC_ASSERT_IMPL(a_rev_no_years, clk_i, rst_ni, $past(swapped, Depth), result_o.whole_years == '0)

endmodule

`default_nettype wire
